/* rtl/sprite_sort_and_batch_core_macros.svh */
// Assertion macros shared by the sprite sort and batch core.
`ifndef SPRITE_SORT_AND_BATCH_CORE_MACROS_SVH
`define SPRITE_SORT_AND_BATCH_CORE_MACROS_SVH

// Same-cycle implication, checked on i_clk outside of reset.
`define SBS_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, checked on i_clk outside of reset.
`define SBS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

/* rtl/sbs_pkg.sv */
// Types, constants and the sort-order compare for the sprite sort and batch core.
package sbs_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int TEX_W           = 16;
    localparam int DEPTH_W         = 32;
    localparam int IDX_W           = 6;
    localparam int VTX_W           = 9;
    localparam int VERTS_PER_ENTRY = 6;

    typedef logic [1:0] t_sbs_mode;

    localparam t_sbs_mode MODE_DEPTH_ASC  = 2'd0;
    localparam t_sbs_mode MODE_DEPTH_DESC = 2'd1;
    localparam t_sbs_mode MODE_TEX_ASC    = 2'd2;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic                      command;
        logic [TEX_W-1:0]          texture_id;
        logic signed [DEPTH_W-1:0] depth;
    } t_sbs_in;

    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic [TEX_W-1:0] texture_id_out;
        logic [VTX_W-1:0] vertex_offset;
        logic             batch_start;
        logic             batch_end;
        logic [VTX_W-1:0] batch_vertex_count;
        logic             overflow;
        logic             last;
    } t_sbs_out;

    // One stored record in arrival order.
    typedef struct packed {
        logic [TEX_W-1:0]          tex;
        logic signed [DEPTH_W-1:0] depth;
    } t_sbs_rec;

    // One entry in the sort chain.
    typedef struct packed {
        logic [TEX_W-1:0]          tex;
        logic signed [DEPTH_W-1:0] depth;
        logic [IDX_W-1:0]          idx;
    } t_sbs_entry;

    typedef struct packed {
        logic       valid;
        t_sbs_entry entry;
    } t_sbs_slot;

    typedef struct packed {
        logic      insert;
        logic      shift;
        t_sbs_mode mode;
    } t_sbs_ctl;

    // True when entry a must go strictly ahead of entry b.
    function automatic logic sbs_before(input t_sbs_mode mode, input t_sbs_entry a,
                                        input t_sbs_entry b);
        logic res;
        unique case (mode)
            MODE_DEPTH_ASC:  res = (a.depth < b.depth);
            MODE_DEPTH_DESC: res = (a.depth > b.depth);
            MODE_TEX_ASC:    res = (a.tex < b.tex);
            default:         res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

/* rtl/sbs_store.sv */
// Arrival-order record store with one write port and one registered read port.
module sbs_store #(
    parameter int DEPTH = sbs_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  sbs_pkg::t_sbs_rec i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output sbs_pkg::t_sbs_rec o_rd_data
);

    sbs_pkg::t_sbs_rec r_mem [DEPTH];
    sbs_pkg::t_sbs_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/sbs_cell.sv */
// One cell of the sorted insertion chain: holds one entry, inserts and shifts with neighbors.
module sbs_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbs_pkg::t_sbs_ctl   i_ctl,
    input  sbs_pkg::t_sbs_entry i_new,
    input  sbs_pkg::t_sbs_slot  i_prev,
    input  logic                i_prev_ins,
    input  sbs_pkg::t_sbs_slot  i_next,
    output sbs_pkg::t_sbs_slot  o_slot,
    output logic                o_ins
);

    logic                r_valid;
    sbs_pkg::t_sbs_entry r_entry;
    logic                n_valid;
    sbs_pkg::t_sbs_entry n_entry;

    // The new entry belongs at or before this place; an empty cell always asserts o_ins.
    assign o_ins = !r_valid || sbs_pkg::sbs_before(i_ctl.mode, i_new, r_entry);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.shift) begin
            n_valid = i_next.valid;
            n_entry = i_next.entry;
        end else if (i_ctl.insert && o_ins) begin
            if (i_prev_ins) begin
                // push right: take the left neighbor's entry
                n_valid = i_prev.valid;
                n_entry = i_prev.entry;
            end else begin
                n_valid = 1'b1;
                n_entry = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_slot.valid = r_valid;
    assign o_slot.entry = r_entry;

endmodule

/* rtl/sprite_sort_and_batch_core.sv */
// Top level of the sprite sort and batch core: store, sort chain, batch marking, output.
// Input channel (i_in_valid / o_in_ready / i_in_data): add commands store one sprite
// entry each, up to MAX_ENTRIES; further adds are dropped and flagged.
// A finish command sorts the held entries stably by sort_mode (written on the
// i_cfg_valid / o_cfg_ready / i_cfg_data port, taken every cycle) and sends one
// result item per entry on the output channel (o_out_valid / i_out_ready / o_out_data)
// with batch start/end marks and the run's vertex count; an empty set gives nothing.
// After a finish is accepted, the store is read through its single read port and each
// record is inserted into the cell chain, one insertion per cycle; the block then
// hands over to emission and sends one result per cycle as long as the receiver takes
// them. o_in_ready is low from the finish until the last result has entered the
// output register. When the receiver stalls, the output register holds its item and
// the chain holds. Reset empties the store and chain, clears the overflow flag and sets
// sort_mode to ascending texture id.
`include "sprite_sort_and_batch_core_macros.svh"

module sprite_sort_and_batch_core #(
    parameter int MAX_ENTRIES = sbs_pkg::MAX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sbs_pkg::t_sbs_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sbs_pkg::t_sbs_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  sbs_pkg::t_sbs_mode i_cfg_data
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]         r_state;
    sbs_pkg::t_sbs_mode r_mode;
    sbs_pkg::t_sbs_mode r_mode_run;
    logic [CW-1:0]      r_cnt;
    logic               r_drop;
    logic [CW-1:0]      r_n;
    logic               r_ovf;
    logic [CW-1:0]      r_rd_addr;
    logic               r_ld_v;
    logic [AW-1:0]      r_ld_idx;
    logic [CW-1:0]      r_rank;
    logic [CW-1:0]      r_run;
    logic [sbs_pkg::TEX_W-1:0] r_prev_tex;
    logic               r_out_valid;
    sbs_pkg::t_sbs_out  r_out;

    logic               w_in_acc;
    logic               w_add;
    logic               w_fin;
    logic               w_wr_en;
    logic               w_rd_en;
    logic               w_emit;
    logic               w_start;
    logic               w_end;
    logic               w_last;
    logic [CW-1:0]      w_runlen;
    sbs_pkg::t_sbs_rec  w_wr_rec;
    sbs_pkg::t_sbs_rec  w_rd_rec;
    sbs_pkg::t_sbs_entry w_new;
    sbs_pkg::t_sbs_ctl  w_ctl;
    sbs_pkg::t_sbs_slot w_slot [MAX_ENTRIES];
    logic               w_ins  [MAX_ENTRIES];

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_add       = w_in_acc && (i_in_data.command == sbs_pkg::CMD_ADD);
    assign w_fin       = w_in_acc && (i_in_data.command == sbs_pkg::CMD_FINISH);
    assign w_wr_en     = w_add && (r_cnt < CW'(MAX_ENTRIES));
    assign w_rd_en     = (r_state == ST_LOAD) && (r_rd_addr != r_n);

    assign w_wr_rec.tex   = i_in_data.texture_id;
    assign w_wr_rec.depth = i_in_data.depth;

    sbs_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (w_wr_rec),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_addr[AW-1:0]),
        .o_rd_data (w_rd_rec)
    );

    assign w_new.tex   = w_rd_rec.tex;
    assign w_new.depth = w_rd_rec.depth;
    assign w_new.idx   = sbs_pkg::IDX_W'(r_ld_idx);

    assign w_ctl.insert = r_ld_v;
    assign w_ctl.shift  = w_emit;
    assign w_ctl.mode   = r_mode_run;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        sbs_pkg::t_sbs_slot w_prev;
        sbs_pkg::t_sbs_slot w_next;
        logic               w_prev_ins;

        if (g == 0) begin : g_head
            assign w_prev     = '0;
            assign w_prev_ins = 1'b0;
        end else begin : g_body
            assign w_prev     = w_slot[g-1];
            assign w_prev_ins = w_ins[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_link
            assign w_next = w_slot[g+1];
        end

        sbs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_new      (w_new),
            .i_prev     (w_prev),
            .i_prev_ins (w_prev_ins),
            .i_next     (w_next),
            .o_slot     (w_slot[g]),
            .o_ins      (w_ins[g])
        );
    end

    // Emit from the chain head whenever the output register is free or being taken.
    assign w_emit   = (r_state == ST_EMIT) && w_slot[0].valid && (!r_out_valid || i_out_ready);
    assign w_last   = !w_slot[1].valid;
    assign w_start  = (r_rank == '0) || (r_prev_tex != w_slot[0].entry.tex);
    assign w_end    = w_last || (w_slot[1].entry.tex != w_slot[0].entry.tex);
    assign w_runlen = w_start ? CW'(1) : (r_run + CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= sbs_pkg::MODE_TEX_ASC;
            r_mode_run  <= sbs_pkg::MODE_TEX_ASC;
            r_cnt       <= '0;
            r_drop      <= 1'b0;
            r_n         <= '0;
            r_ovf       <= 1'b0;
            r_rd_addr   <= '0;
            r_ld_v      <= 1'b0;
            r_rank      <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            r_ld_v <= w_rd_en;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_wr_en) begin
                        r_cnt <= r_cnt + CW'(1);
                    end else if (w_add) begin
                        r_drop <= 1'b1;
                    end
                    if (w_fin) begin
                        // hand the set to the sort and clear the store
                        r_n        <= r_cnt;
                        r_ovf      <= r_drop;
                        r_mode_run <= r_mode;
                        r_cnt      <= '0;
                        r_drop     <= 1'b0;
                        r_rd_addr  <= '0;
                        r_rank     <= '0;
                        r_run      <= '0;
                        if (r_cnt != '0) begin
                            r_state <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    if (w_rd_en) begin
                        r_rd_addr <= r_rd_addr + CW'(1);
                    end else if (!r_ld_v) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_rank <= r_rank + CW'(1);
                        r_run  <= w_runlen;
                        if (w_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ld_idx <= r_rd_addr[AW-1:0];
        if (w_emit) begin
            r_prev_tex               <= w_slot[0].entry.tex;
            r_out.entry_index        <= w_slot[0].entry.idx;
            r_out.texture_id_out     <= w_slot[0].entry.tex;
            r_out.vertex_offset      <= sbs_pkg::VTX_W'(r_rank)
                                        * sbs_pkg::VTX_W'(sbs_pkg::VERTS_PER_ENTRY);
            r_out.batch_start        <= w_start;
            r_out.batch_end          <= w_end;
            r_out.batch_vertex_count <= w_end ? (sbs_pkg::VTX_W'(w_runlen)
                                        * sbs_pkg::VTX_W'(sbs_pkg::VERTS_PER_ENTRY)) : '0;
            r_out.overflow           <= r_ovf;
            r_out.last               <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SBS_ASSERT_NOW(a_emit_not_empty, r_state == ST_EMIT, w_slot[0].valid,
        "sort chain empty while emitting")
    `SBS_ASSERT_NOW(a_idle_chain_empty, r_state == ST_IDLE, !w_slot[0].valid,
        "sort chain holds entries while idle")
    `SBS_ASSERT_NOW(a_load_addr_range, r_state == ST_LOAD, r_rd_addr <= r_n,
        "store read address beyond entry count")
    `SBS_ASSERT_NEXT(a_last_to_idle, w_emit && w_last, r_state == ST_IDLE,
        "block not idle after final result")

endmodule
